// ----- src/scc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the strongly connected component labeler.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned VW = $clog2(MaxVertices);
  localparam int unsigned CW = VW + 1;

  typedef logic [VW-1:0] vtx_t;
  typedef logic [CW-1:0] cnt_t;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_EDGE  = 2'd1,
    KIND_SOLVE = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_INIT,
    ST_ROOT,
    ST_VISIT,
    ST_TOP,
    ST_SCAN,
    ST_CHECK,
    ST_COLLAPSE_RD,
    ST_COLLAPSE,
    ST_RETURN,
    ST_POP_RD,
    ST_POP,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

endpackage

// ----- src/strongly_connected_components.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strongly_connected_components
// Path-based strongly connected component labeler with a sequential search.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake        Payload
// in_       input      valid / stall    kind, source_vertex, target_vertex
// out_      output     valid / stall    vertex, component, component_count, last
// cfg_      input      valid / ready    data (vertex_count)
//
// A clear item writes all MaxVertices adjacency rows, one per cycle; an edge
// item reads its row and then writes it back through the one memory port.
// A solve item walks the graph one step per cycle: each vertex passes through
// visit and return, each scanned neighbor position is checked in turn, each
// path pop or search pop reads the stack top through a register, and the
// result phase offers one vertex at a time and waits while out_stall is high.
// Reset is synchronous and active low; it starts a clearing pass over the
// adjacency memory, with in_stall high meanwhile.
// The result register holds a request while out_stall is high.
// ----------------------------------------------------------------------------
module strongly_connected_components (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [5:0] in_source_vertex,
  input  logic [5:0] in_target_vertex,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_vertex,
  output logic [5:0] out_component,
  output logic [6:0] out_component_count,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  localparam int unsigned VW = scc_pkg::VW;
  localparam int unsigned CW = scc_pkg::CW;
  localparam int unsigned N  = scc_pkg::MaxVertices;

  scc_pkg::state_t state_r, state_nxt;

  // Adjacency rows, one port: read or write at one address per cycle.
  logic [N-1:0]  adj_mem [N];
  logic [N-1:0]  adj_rd_r;
  logic          adj_we;
  scc_pkg::vtx_t adj_addr;
  logic [N-1:0]  adj_wdata;

  // Per-vertex stores; visited and assigned marks are valid bits.
  logic [CW-1:0] pre_mem [N];
  logic [VW-1:0] lab_mem [N];
  logic [N-1:0]  pre_valid_r, lab_valid_r;
  logic [VW-1:0] sstk [N];
  logic [VW-1:0] pstk [N];
  logic [CW-1:0] pstk_pre [N];
  logic [VW-1:0] cstk_v [N];
  logic [CW-1:0] cstk_c [N];
  logic [CW-1:0] ssp_r, psp_r, csp_r;
  logic [CW-1:0] pre_cnt_r, comp_cnt_r;
  logic [CW-1:0] vc_r, n_eff;
  logic [CW-1:0] root_r, idx_r, cur_r;
  scc_pkg::vtx_t v_r, t_r;
  scc_pkg::vtx_t src_r, tgt_r;

  logic [CW-1:0] pre_t_r;

  // Registered reads of the path and search stack tops.
  logic [VW-1:0] ptop_v_r, stop_r;
  logic [CW-1:0] ptop_pre_r;

  assign n_eff = (vc_r > CW'(N)) ? CW'(N) : vc_r;
  assign cfg_ready = (state_r == scc_pkg::ST_IDLE);
  assign in_stall  = (state_r != scc_pkg::ST_IDLE);

  logic accept;
  assign accept = in_valid && !in_stall;

  // Memory access
  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_addr] <= adj_wdata;
    end
    adj_rd_r <= adj_mem[adj_addr];
  end

  // The tops are registered reads at the current stack pointers, so a state that reads
  // them must not follow a state that moved the same pointer.
  always_ff @(posedge clk) begin
    ptop_v_r   <= pstk[psp_r[VW-1:0] - VW'(1)];
    ptop_pre_r <= pstk_pre[psp_r[VW-1:0] - VW'(1)];
    stop_r     <= sstk[ssp_r[VW-1:0] - VW'(1)];
  end

  // Scan position: first set bit at or above cur_r below n_eff.
  logic [N-1:0]  scan_mask;
  logic          scan_hit;
  scc_pkg::vtx_t scan_idx;
  always_comb begin
    scan_hit = 1'b0;
    scan_idx = '0;
    for (int i = 0; i < N; i++) begin
      scan_mask[i] = adj_rd_r[i] && (CW'(i) >= cur_r) && (CW'(i) < n_eff);
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (scan_mask[i]) begin
        scan_hit = 1'b1;
        scan_idx = VW'(i);
      end
    end
  end

  logic          edge_ok;
  assign edge_ok = (CW'(src_r) < n_eff) && (CW'(tgt_r) < n_eff);

  always_comb begin
    state_nxt = state_r;
    adj_we    = 1'b0;
    adj_addr  = v_r;
    adj_wdata = '0;
    unique case (state_r)
      scc_pkg::ST_IDLE: begin
        adj_addr = in_source_vertex;
        if (accept) begin
          case (in_kind)
            scc_pkg::KIND_CLEAR: state_nxt = scc_pkg::ST_CLEAR;
            scc_pkg::KIND_EDGE:  state_nxt = scc_pkg::ST_INIT;
            scc_pkg::KIND_SOLVE: state_nxt = scc_pkg::ST_ROOT;
            default:             state_nxt = scc_pkg::ST_IDLE;
          endcase
        end
      end
      scc_pkg::ST_CLEAR: begin
        adj_we   = 1'b1;
        adj_addr = idx_r[VW-1:0];
        if (idx_r == CW'(N - 1)) state_nxt = scc_pkg::ST_IDLE;
      end
      scc_pkg::ST_INIT: begin
        // Edge insert: row was read on acceptance.
        adj_addr  = src_r;
        adj_wdata = adj_rd_r | (N'(1) << tgt_r);
        adj_we    = edge_ok;
        state_nxt = scc_pkg::ST_IDLE;
      end
      scc_pkg::ST_ROOT: begin
        if (root_r >= n_eff) begin
          state_nxt = scc_pkg::ST_EMIT_RD;
        end else if (pre_valid_r[root_r[VW-1:0]]) begin
          state_nxt = scc_pkg::ST_ROOT;
        end else begin
          state_nxt = scc_pkg::ST_VISIT;
        end
      end
      scc_pkg::ST_VISIT: state_nxt = scc_pkg::ST_TOP;
      scc_pkg::ST_TOP: begin
        state_nxt = (csp_r == '0) ? scc_pkg::ST_ROOT : scc_pkg::ST_SCAN;
      end
      // The row of v_r is read here and scanned in the next state.
      scc_pkg::ST_SCAN: state_nxt = scc_pkg::ST_CHECK;
      scc_pkg::ST_CHECK: begin
        if (!scan_hit) begin
          state_nxt = scc_pkg::ST_RETURN;
        end else if (!pre_valid_r[scan_idx]) begin
          state_nxt = scc_pkg::ST_VISIT;
        end else if (!lab_valid_r[scan_idx]) begin
          state_nxt = scc_pkg::ST_COLLAPSE;
        end else begin
          state_nxt = scc_pkg::ST_TOP;
        end
      end
      scc_pkg::ST_COLLAPSE_RD: state_nxt = scc_pkg::ST_COLLAPSE;
      scc_pkg::ST_COLLAPSE: begin
        if (psp_r == '0 || ptop_pre_r <= pre_t_r) begin
          state_nxt = scc_pkg::ST_TOP;
        end else begin
          state_nxt = scc_pkg::ST_COLLAPSE_RD;
        end
      end
      scc_pkg::ST_RETURN: begin
        if (psp_r != '0 && ptop_v_r == v_r) begin
          state_nxt = scc_pkg::ST_POP;
        end else begin
          state_nxt = scc_pkg::ST_TOP;
        end
      end
      scc_pkg::ST_POP_RD: state_nxt = scc_pkg::ST_POP;
      scc_pkg::ST_POP: begin
        if (ssp_r == '0 || stop_r == v_r) begin
          state_nxt = scc_pkg::ST_TOP;
        end else begin
          state_nxt = scc_pkg::ST_POP_RD;
        end
      end
      scc_pkg::ST_EMIT_RD: begin
        state_nxt = (idx_r >= n_eff) ? scc_pkg::ST_IDLE : scc_pkg::ST_EMIT;
      end
      scc_pkg::ST_EMIT: begin
        if (!out_stall) state_nxt = scc_pkg::ST_EMIT_RD;
      end
      default: state_nxt = scc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scc_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  scc_pkg::vtx_t top_idx;
  assign top_idx = csp_r[VW-1:0] - VW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r        <= CW'(N);
      pre_valid_r <= '0;
      lab_valid_r <= '0;
      ssp_r <= '0; psp_r <= '0; csp_r <= '0;
      pre_cnt_r <= '0; comp_cnt_r <= '0;
      idx_r <= '0; root_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) vc_r <= cfg_data;
      unique case (state_r)
        scc_pkg::ST_IDLE: begin
          idx_r <= '0;
          root_r <= '0;
          if (accept) begin
            src_r  <= in_source_vertex;
            tgt_r  <= in_target_vertex;
            pre_valid_r <= '0; lab_valid_r <= '0;
            ssp_r <= '0; psp_r <= '0; csp_r <= '0;
            pre_cnt_r <= '0; comp_cnt_r <= '0;
          end
        end
        scc_pkg::ST_CLEAR: idx_r <= idx_r + CW'(1);
        scc_pkg::ST_ROOT: begin
          t_r <= root_r[VW-1:0];
          root_r <= root_r + CW'(1);
        end
        scc_pkg::ST_VISIT: begin
          pre_mem[t_r] <= pre_cnt_r;
          pre_valid_r[t_r] <= 1'b1;
          pre_cnt_r <= pre_cnt_r + CW'(1);
          sstk[ssp_r[VW-1:0]] <= t_r;
          pstk[psp_r[VW-1:0]] <= t_r;
          pstk_pre[psp_r[VW-1:0]] <= pre_cnt_r;
          cstk_v[csp_r[VW-1:0]] <= t_r;
          cstk_c[csp_r[VW-1:0]] <= '0;
          ssp_r <= ssp_r + CW'(1);
          psp_r <= psp_r + CW'(1);
          csp_r <= csp_r + CW'(1);
        end
        scc_pkg::ST_TOP: begin
          v_r   <= cstk_v[top_idx];
          cur_r <= cstk_c[top_idx];
        end
        scc_pkg::ST_CHECK: begin
          if (scan_hit) begin
            cstk_c[top_idx] <= CW'(scan_idx) + CW'(1);
            t_r     <= scan_idx;
            pre_t_r <= pre_mem[scan_idx];
          end else begin
            csp_r <= csp_r - CW'(1);
          end
        end
        scc_pkg::ST_COLLAPSE: begin
          if (psp_r != '0 && ptop_pre_r > pre_t_r) begin
            psp_r <= psp_r - CW'(1);
          end
        end
        scc_pkg::ST_RETURN: begin
          if (psp_r != '0 && ptop_v_r == v_r) psp_r <= psp_r - CW'(1);
        end
        scc_pkg::ST_POP: begin
          if (ssp_r != '0) begin
            lab_mem[stop_r] <= comp_cnt_r[VW-1:0];
            lab_valid_r[stop_r] <= 1'b1;
            ssp_r <= ssp_r - CW'(1);
          end
          if (ssp_r == '0 || stop_r == v_r) begin
            comp_cnt_r <= comp_cnt_r + CW'(1);
          end
        end
        scc_pkg::ST_EMIT_RD: begin
          if (idx_r < n_eff) begin
            out_valid <= 1'b1;
            out_vertex <= idx_r[VW-1:0];
            out_component <= lab_mem[idx_r[VW-1:0]];
            out_component_count <= comp_cnt_r;
            out_last <= (idx_r + CW'(1) == n_eff);
            idx_r <= idx_r + CW'(1);
          end
        end
        scc_pkg::ST_EMIT: if (!out_stall) out_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  // A result is only ever offered from the emit state.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == scc_pkg::ST_EMIT)
    else $error("result valid outside emit");
  // Search stack never holds fewer entries than the path stack.
  assert property (@(posedge clk) disable iff (!rst_n)
    psp_r <= ssp_r) else $error("path stack deeper than search stack");
  // The component count never passes the preorder count.
  assert property (@(posedge clk) disable iff (!rst_n)
    comp_cnt_r <= pre_cnt_r) else $error("more components than visits");

endmodule
